// ----- sv/swld_pkg.sv -----
// ============================================================================
// swld_pkg: sync word / length deframer package
// Shared widths, phase encoding and the sync signature table.
// ============================================================================
package swld_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 24;
    localparam int SIG_LEN         = 20;
    localparam int LEN_FIELD_BYTES = 4;
    localparam int MIN_LEN         = 8;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1000000);

    // "#$NETWORK\0DATA\0BLOCK", zero padded; the first SIG_LEN entries are used
    localparam logic [BYTE_W-1:0] SIG_TABLE [32] = '{
        8'h23, 8'h24, 8'h4e, 8'h45, 8'h54, 8'h57, 8'h4f, 8'h52,
        8'h4b, 8'h00, 8'h44, 8'h41, 8'h54, 8'h41, 8'h00, 8'h42,
        8'h4c, 8'h4f, 8'h43, 8'h4b, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

endpackage

// ----- sv/swld_rx_if.sv -----
// ============================================================================
// swld_rx_if: received byte channel
// valid/ready channel carrying one received byte per request.
// ============================================================================
interface swld_rx_if;
    import swld_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- sv/swld_blk_if.sv -----
// ============================================================================
// swld_blk_if: deframed block byte channel
// valid/ready channel carrying one block byte or one error per request.
// ============================================================================
interface swld_blk_if;
    import swld_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] block_byte;
    logic              first_byte;
    logic              last_byte;
    logic              length_error;
    logic [LEN_W-1:0]  block_length;

    modport source (output valid, output block_byte, output first_byte,
                    output last_byte, output length_error, output block_length,
                    input ready);
    modport sink   (input valid, input block_byte, input first_byte,
                    input last_byte, input length_error, input block_length,
                    output ready);
endinterface

// ----- sv/sync_word_length_deframer.sv -----
// ============================================================================
// sync_word_length_deframer: sync word hunt and length-prefixed deframing
// Hunts for a 20-byte sync signature, reads a 4-byte LE length, then passes
// the block bytes out with first/last marks or flags a bad length.
// ============================================================================
// Output: a request that produces a result shows it on blk in the cycle after
//   it is taken on rx (single output register).
// Throughput: one rx request per cycle; rx.ready drops only while a result
//   sits in the output register and blk stalls.
// Reset: rst_n asynchronous low; hunt phase, window zero, limit 1000000.
// ============================================================================
module sync_word_length_deframer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [swld_pkg::LEN_W-1:0] cfg_wr_data,
    swld_rx_if.sink                    rx,
    swld_blk_if.source                 blk
);
    import swld_pkg::*;

    localparam int WIN_LEN = SIG_LEN - 1;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  max_len_reg;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] win_reg  [WIN_LEN];
    logic [BYTE_W-1:0] win_next [WIN_LEN];
    logic [1:0]        cnt_reg, cnt_next;      // length byte index
    logic [LEN_W-1:0]  len_reg, len_next;      // low 24 bits of length field
    logic              ovf_reg, ovf_next;      // length field top byte nonzero
    logic [LEN_W-1:0]  left_reg, left_next;    // block bytes still to pass
    logic              first_reg, first_next;  // next data byte opens the block

    // output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_first_reg;
    logic              out_last_reg;
    logic              out_err_reg;
    logic [LEN_W-1:0]  out_len_reg;

    // result of the current request
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    logic              res_first;
    logic              res_last;
    logic              res_err;
    logic [LEN_W-1:0]  res_len;

    logic              accept;
    logic              sig_match;
    logic              len_done;   // final length byte arrives
    logic              len_ovf;    // overflow flag including this byte
    logic              len_bad;

    // Output register frees up when empty or when its result is taken
    assign rx.ready = !out_valid_reg || blk.ready;
    assign accept   = rx.valid && rx.ready;

    // ------------------------------------------------------------------
    // Parallel signature compare: window plus current byte
    // ------------------------------------------------------------------
    always_comb
    begin
        sig_match = (rx.rx_byte == SIG_TABLE[SIG_LEN-1]);
        for (int i = 0; i < WIN_LEN; i++)
        begin
            sig_match = sig_match && (win_reg[i] == SIG_TABLE[i]);
        end
    end

    // Length check happens on the fourth length byte; the top byte only
    // matters as an overflow flag since the limit is 24 bits wide.
    assign len_done = (phase_reg == PH_LEN) && (cnt_reg == 2'(LEN_FIELD_BYTES - 1));
    assign len_ovf  = ovf_reg || (rx.rx_byte != '0);
    assign len_bad  = len_ovf || (len_reg < LEN_W'(MIN_LEN)) || (len_reg > max_len_reg);

    // ------------------------------------------------------------------
    // Next phase
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_LEN:
            begin
                if (len_done)
                begin
                    phase_next = len_bad ? PH_HUNT : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (left_reg <= LEN_W'(1))
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                // unused code behaves as hunt
                phase_next = sig_match ? PH_LEN : PH_HUNT;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and result
    // ------------------------------------------------------------------
    always_comb
    begin
        win_next   = win_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        left_next  = left_reg;
        first_next = first_reg;

        res_valid  = 1'b0;
        res_byte   = rx.rx_byte;
        res_first  = 1'b0;
        res_last   = 1'b0;
        res_err    = 1'b0;
        res_len    = len_reg;

        case (phase_reg)
            PH_LEN:
            begin
                cnt_next = cnt_reg + 2'd1;
                case (cnt_reg)
                    2'd0:    len_next[7:0]   = rx.rx_byte;
                    2'd1:    len_next[15:8]  = rx.rx_byte;
                    2'd2:    len_next[23:16] = rx.rx_byte;
                    default: ovf_next        = len_ovf;
                endcase
                if (len_done)
                begin
                    if (len_bad)
                    begin
                        res_valid = 1'b1;
                        res_byte  = '0;
                        res_last  = 1'b1;
                        res_err   = 1'b1;
                        res_len   = len_ovf ? '1 : len_reg;
                    end
                    else
                    begin
                        left_next  = len_reg - LEN_W'(LEN_FIELD_BYTES);
                        first_next = 1'b1;
                    end
                end
            end
            PH_DATA:
            begin
                res_valid  = 1'b1;
                res_first  = first_reg;
                res_last   = (left_reg <= LEN_W'(1));
                first_next = 1'b0;
                if (left_reg != '0)
                begin
                    left_next = left_reg - LEN_W'(1);
                end
            end
            default:
            begin
                if (sig_match)
                begin
                    for (int i = 0; i < WIN_LEN; i++)
                    begin
                        win_next[i] = '0;
                    end
                    cnt_next  = '0;
                    len_next  = '0;
                    ovf_next  = 1'b0;
                    left_next = '0;
                end
                else
                begin
                    for (int i = 0; i < WIN_LEN - 1; i++)
                    begin
                        win_next[i] = win_reg[i+1];
                    end
                    win_next[WIN_LEN-1] = rx.rx_byte;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
            phase_reg   <= PH_HUNT;
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
            cnt_reg     <= '0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            left_reg    <= '0;
            first_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                win_reg   <= win_next;
                cnt_reg   <= cnt_next;
                len_reg   <= len_next;
                ovf_reg   <= ovf_next;
                left_reg  <= left_next;
                first_reg <= first_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= res_valid;
        end
        else if (blk.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_byte_reg  <= res_byte;
            out_first_reg <= res_first;
            out_last_reg  <= res_last;
            out_err_reg   <= res_err;
            out_len_reg   <= res_len;
        end
    end

    assign blk.valid        = out_valid_reg;
    assign blk.block_byte   = out_byte_reg;
    assign blk.first_byte   = out_first_reg;
    assign blk.last_byte    = out_last_reg;
    assign blk.length_error = out_err_reg;
    assign blk.block_length = out_len_reg;

endmodule
